### rtl/slnpt_pkg.sv
package slnpt_pkg;

	localparam int GRID_COLS      = 10;
	localparam int STACK_DEPTH    = 16;
	localparam int LANES          = 4;
	localparam int KEY_CODES      = 56;
	localparam int MAX_RESULTS    = 40;

	localparam int DEPTH_W  = $clog2(STACK_DEPTH + 1);
	localparam int STACK_AW = $clog2(LANES * STACK_DEPTH);
	localparam int IDX_W    = 7;
	localparam int CNT_W    = 6;

	localparam logic [2:0] NO_LANE = 3'd4;

	localparam logic [1:0] EV_ON    = 2'd0;
	localparam logic [1:0] EV_OFF   = 2'd1;
	localparam logic [1:0] EV_ALL   = 2'd2;
	localparam logic [1:0] EV_LEADS = 2'd3;

	localparam logic [1:0] CFG_JAM     = 2'd0;
	localparam logic [1:0] CFG_SMODE   = 2'd1;
	localparam logic [1:0] CFG_VOICING = 2'd2;

	localparam logic [1:0] ROW_X0   [4] = '{2'd1, 2'd1, 2'd2, 2'd3};
	localparam logic [1:0] ROW_LANE [4] = '{2'd3, 2'd2, 2'd1, 2'd0};

	typedef enum logic [2:0] {
		REQ_PRESS     = 3'd0,
		REQ_RELEASE   = 3'd1,
		REQ_SUSTAIN   = 3'd2,
		REQ_HOLD      = 3'd3,
		REQ_ALL_OFF   = 3'd4,
		REQ_LEADS_OFF = 3'd5
	} req_t;

	typedef enum logic [3:0] {
		E_ON_PRI,
		E_ON_PAR,
		E_OFF_PAR,
		E_OFF_DRONE,
		E_OFF_KEY,
		E_BACK_ON,
		E_FLUSH,
		E_ALL,
		E_LEADS
	} esel_t;

	// Packed so that the first field sits in the highest bits.
	typedef struct packed {
		logic [3:0] interval;
		logic       drone;
		logic       legato;
		logic [2:0] lane;
		logic [6:0] voice;
		logic [1:0] kind;
	} res_t;

	typedef struct packed {
		logic  load;
		logic  scan_rd;
		logic  st_top;
		logic  emit;
		esel_t esel;
		logic  finish;
		logic  press_wr;
		logic  rel_wr;
		logic  clr_mark;
		logic  flush_clr;
		logic  idx_clr;
		logic  idx_inc;
		logic  found_clr;
		logic  found_set;
		logic  shift_wr;
		logic  depth_dec;
		logic  owner_set;
		logic  sus_upd;
		logic  hold_tgl;
		logic  all_off;
		logic  leads_off;
		logic  cnt_clr;
		logic  cnt_inc;
	} cmd_t;

	typedef struct packed {
		logic can_emit;
		logic out_free;
		logic pend_v;
		req_t req;
		logic grid_ok;
		logic jam;
		logic active;
		logic drone;
		logic smode;
		logic held_any;
		logic mark_ivl_nz;
		logic new_ivl_nz;
		logic sus_flush;
		logic hold_on;
		logic depth_nz;
		logic hit;
		logic rm_done;
		logic found;
		logic owner;
		logic fl_done;
		logic fl_hit;
	} stat_t;

	function automatic logic [1:0] code_row(input logic [5:0] c);
		if (c < 6'd14) return 2'd0;
		else if (c < 6'd28) return 2'd1;
		else if (c < 6'd42) return 2'd2;
		else return 2'd3;
	endfunction

	function automatic logic grid_ok(input logic [5:0] c);
		logic [1:0] y;
		logic [5:0] x;
		logic [5:0] x0;
		y  = code_row(c);
		x  = c - 6'(14 * int'(y));
		x0 = {4'd0, ROW_X0[y]};
		return (c < 6'(KEY_CODES)) && (x >= x0) && ((x - x0) < 6'(GRID_COLS));
	endfunction

	function automatic logic [1:0] grid_lane(input logic [5:0] c);
		return ROW_LANE[code_row(c)];
	endfunction

	function automatic logic [3:0] voicing_interval(input logic [1:0] v);
		case (v)
			2'd1:    return 4'd12;
			2'd2:    return 4'd7;
			default: return 4'd0;
		endcase
	endfunction

	function automatic logic [STACK_AW-1:0] st_addr(input logic [1:0] lane, input int i);
		return STACK_AW'(int'(lane) * STACK_DEPTH + i);
	endfunction

endpackage

### rtl/slnpt_dp.sv
module slnpt_dp
	import slnpt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_data,
	input  logic [15:0] in_data,
	input  logic        out_ready,
	input  cmd_t        cmd,
	output stat_t       st,
	output logic        out_valid,
	output res_t        out_res,
	output logic        out_last
);

	logic [2:0]         jam_q;
	logic               smode_q;
	logic [1:0]         voicing_q;
	logic [2:0]         req_q;
	logic [5:0]         code_q;
	logic               lvl_q;
	logic [63:0]        valid_q;
	logic [63:0]        drone_q;
	logic [DEPTH_W-1:0] depth_q [LANES];
	logic               held_q;
	logic               hold_q;
	logic [IDX_W-1:0]   idx_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               found_q;
	logic               owner_q;
	logic               pend_v_q;
	res_t               pend_q;
	logic               out_v_q;
	res_t               out_q;
	logic               out_last_q;

	// Mark entry: physical, sustained, partner interval.
	logic [5:0]          mark_mem [64];
	logic [5:0]          mark_rd_q;
	logic [5:0]          stack_mem [LANES*STACK_DEPTH];
	logic [5:0]          st_rd_q;

	logic [1:0]          lane_c;
	logic                jam_c;
	logic [DEPTH_W-1:0]  depth_c;
	logic [3:0]          ivl_new;
	logic                held_any;
	logic                push;
	logic [5:0]          mark_ra;
	logic [STACK_AW-1:0] st_ra;
	logic                out_free;
	logic                can_emit;
	logic                move;
	res_t                res_new;

	assign lane_c   = grid_lane(code_q);
	assign jam_c    = {1'b0, lane_c} < jam_q;
	assign depth_c  = depth_q[lane_c];
	assign ivl_new  = voicing_interval(voicing_q);
	assign held_any = held_q || hold_q;
	assign push     = cmd.press_wr && !jam_c && smode_q && (depth_c < DEPTH_W'(STACK_DEPTH));
	assign mark_ra  = cmd.scan_rd ? idx_q[5:0] : code_q;
	assign st_ra    = cmd.st_top ? st_addr(lane_c, int'(depth_c) - 1)
	                             : st_addr(lane_c, int'(idx_q));
	assign out_free = !out_v_q || out_ready;
	assign can_emit = !pend_v_q || out_free;
	assign move     = (cmd.emit || cmd.finish) && pend_v_q;

	always_comb begin
		res_new = '0;
		res_new.lane = NO_LANE;
		case (cmd.esel)
			E_ON_PRI: begin
				res_new.kind   = EV_ON;
				res_new.voice  = {1'b0, code_q};
				res_new.lane   = jam_c ? NO_LANE : {1'b0, lane_c};
				res_new.legato = !jam_c && smode_q && (depth_c != '0);
				res_new.drone  = jam_c;
			end
			E_ON_PAR: begin
				res_new.kind     = EV_ON;
				res_new.voice    = {1'b1, code_q};
				res_new.drone    = 1'b1;
				res_new.interval = ivl_new;
			end
			E_OFF_PAR: begin
				res_new.kind  = EV_OFF;
				res_new.voice = {1'b1, code_q};
			end
			E_OFF_DRONE: begin
				res_new.kind  = EV_OFF;
				res_new.voice = {1'b0, code_q};
			end
			E_OFF_KEY: begin
				res_new.kind  = EV_OFF;
				res_new.voice = {1'b0, code_q};
				res_new.lane  = {1'b0, lane_c};
			end
			E_BACK_ON: begin
				res_new.kind   = EV_ON;
				res_new.voice  = {1'b0, st_rd_q};
				res_new.lane   = {1'b0, lane_c};
				res_new.legato = 1'b1;
			end
			E_FLUSH: begin
				res_new.kind  = EV_OFF;
				res_new.voice = {1'b0, idx_q[5:0]};
				res_new.lane  = {1'b0, grid_lane(idx_q[5:0])};
			end
			E_ALL:   res_new.kind = EV_ALL;
			E_LEADS: res_new.kind = EV_LEADS;
			default: res_new.kind = EV_ALL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jam_q     <= '0;
			smode_q   <= 1'b0;
			voicing_q <= '0;
			valid_q   <= '0;
			for (int l = 0; l < LANES; l++) depth_q[l] <= '0;
			held_q    <= 1'b0;
			hold_q    <= 1'b0;
			idx_q     <= '0;
			cnt_q     <= '0;
			found_q   <= 1'b0;
			owner_q   <= 1'b0;
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_JAM:     jam_q     <= cfg_data;
					CFG_SMODE:   smode_q   <= cfg_data[0];
					CFG_VOICING: voicing_q <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (cmd.press_wr) valid_q[code_q] <= 1'b1;
			if (cmd.clr_mark) valid_q[code_q] <= 1'b0;
			if (cmd.flush_clr) valid_q[idx_q[5:0]] <= 1'b0;
			if (cmd.all_off) valid_q <= '0;
			if (cmd.leads_off) valid_q <= valid_q & drone_q;
			if (push) depth_q[lane_c] <= depth_c + 1'b1;
			if (cmd.depth_dec && found_q) depth_q[lane_c] <= depth_c - 1'b1;
			if (cmd.all_off || cmd.leads_off) begin
				for (int l = 0; l < LANES; l++) depth_q[l] <= '0;
			end
			if (cmd.sus_upd) held_q <= lvl_q;
			if (cmd.hold_tgl) hold_q <= !hold_q;
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
			if (cmd.cnt_clr) cnt_q <= '0;
			else if (cmd.cnt_inc) cnt_q <= cnt_q + 1'b1;
			if (cmd.found_clr) found_q <= 1'b0;
			else if (cmd.found_set) found_q <= 1'b1;
			if (cmd.owner_set) owner_q <= (depth_c != '0) && (st_rd_q == code_q);
			if (cmd.emit) pend_v_q <= 1'b1;
			else if (cmd.finish) pend_v_q <= 1'b0;
			if (move) out_v_q <= 1'b1;
			else if (out_v_q && out_ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= in_data[2:0];
			code_q <= in_data[8:3];
			lvl_q  <= in_data[9];
		end
		if (cmd.press_wr) drone_q[code_q] <= jam_c;
		if (cmd.emit) pend_q <= res_new;
		if (move) begin
			out_q      <= pend_q;
			out_last_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.press_wr) mark_mem[code_q] <= {2'b10, jam_c ? ivl_new : 4'd0};
		else if (cmd.rel_wr)
			mark_mem[code_q] <= {1'b0, !drone_q[code_q] && held_any, mark_rd_q[3:0]};
		mark_rd_q <= mark_mem[mark_ra];
	end

	always_ff @(posedge clk) begin
		if (push) stack_mem[st_addr(lane_c, int'(depth_c))] <= code_q;
		else if (cmd.shift_wr) stack_mem[st_addr(lane_c, int'(idx_q) - 1)] <= st_rd_q;
		st_rd_q <= stack_mem[st_ra];
	end

	always_comb begin
		st.can_emit    = can_emit;
		st.out_free    = out_free;
		st.pend_v      = pend_v_q;
		st.req         = req_t'(req_q);
		st.grid_ok     = grid_ok(code_q);
		st.jam         = jam_c;
		st.active      = valid_q[code_q];
		st.drone       = valid_q[code_q] && drone_q[code_q];
		st.smode       = smode_q;
		st.held_any    = held_any;
		st.mark_ivl_nz = mark_rd_q[3:0] != 4'd0;
		st.new_ivl_nz  = ivl_new != 4'd0;
		st.sus_flush   = held_q && !lvl_q && !hold_q;
		st.hold_on     = hold_q;
		st.depth_nz    = depth_c != '0;
		st.hit         = st_rd_q == code_q;
		st.rm_done     = idx_q >= IDX_W'(depth_c);
		st.found       = found_q;
		st.owner       = owner_q;
		st.fl_done     = (idx_q == IDX_W'(KEY_CODES)) || (cnt_q == CNT_W'(MAX_RESULTS));
		st.fl_hit      = valid_q[idx_q[5:0]] && mark_rd_q[4] && !mark_rd_q[5];
	end

	assign out_valid = out_v_q;
	assign out_res   = out_q;
	assign out_last  = out_last_q;

endmodule

### rtl/slnpt_ctrl.sv
module slnpt_ctrl
	import slnpt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	typedef enum logic [15:0] {
		S_IDLE       = 16'h0001,
		S_DECODE     = 16'h0002,
		S_PRESS      = 16'h0004,
		S_DRONE_OFF  = 16'h0008,
		S_PARTNER_ON = 16'h0010,
		S_REL        = 16'h0020,
		S_TOP_RD     = 16'h0040,
		S_TOP_CHK    = 16'h0080,
		S_RM_RD      = 16'h0100,
		S_RM_CHK     = 16'h0200,
		S_RM_END     = 16'h0400,
		S_BACK_RD    = 16'h0800,
		S_BACK_CHK   = 16'h1000,
		S_FL_RD      = 16'h2000,
		S_FL_CHK     = 16'h4000,
		S_FINISH     = 16'h8000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.cnt_clr = 1'b1;
				case (st.req)
					REQ_PRESS:   state_d = st.grid_ok ? S_PRESS : S_FINISH;
					REQ_RELEASE: state_d = st.grid_ok ? S_REL : S_FINISH;
					REQ_SUSTAIN: begin
						cmd.sus_upd = 1'b1;
						cmd.idx_clr = 1'b1;
						state_d = st.sus_flush ? S_FL_RD : S_FINISH;
					end
					REQ_HOLD: begin
						cmd.hold_tgl = 1'b1;
						cmd.idx_clr  = 1'b1;
						state_d = st.hold_on ? S_FL_RD : S_FINISH;
					end
					REQ_ALL_OFF: begin
						if (st.can_emit) begin
							cmd.emit    = 1'b1;
							cmd.esel    = E_ALL;
							cmd.all_off = 1'b1;
							state_d     = S_FINISH;
						end
					end
					REQ_LEADS_OFF: begin
						if (st.can_emit) begin
							cmd.emit      = 1'b1;
							cmd.esel      = E_LEADS;
							cmd.leads_off = 1'b1;
							state_d       = S_FINISH;
						end
					end
					default: state_d = S_FINISH;
				endcase
			end
			S_PRESS: begin
				if (st.can_emit) begin
					cmd.emit = 1'b1;
					if (st.jam && st.drone) begin
						if (st.mark_ivl_nz) begin
							cmd.esel = E_OFF_PAR;
							state_d  = S_DRONE_OFF;
						end else begin
							cmd.esel     = E_OFF_DRONE;
							cmd.clr_mark = 1'b1;
							state_d      = S_FINISH;
						end
					end else begin
						cmd.esel     = E_ON_PRI;
						cmd.press_wr = 1'b1;
						state_d = (st.jam && st.new_ivl_nz) ? S_PARTNER_ON : S_FINISH;
					end
				end
			end
			S_DRONE_OFF: begin
				if (st.can_emit) begin
					cmd.emit     = 1'b1;
					cmd.esel     = E_OFF_DRONE;
					cmd.clr_mark = 1'b1;
					state_d      = S_FINISH;
				end
			end
			S_PARTNER_ON: begin
				if (st.can_emit) begin
					cmd.emit = 1'b1;
					cmd.esel = E_ON_PAR;
					state_d  = S_FINISH;
				end
			end
			S_REL: begin
				if (!st.active) begin
					state_d = S_FINISH;
				end else if (st.drone || st.held_any || st.smode) begin
					cmd.rel_wr = 1'b1;
					state_d = (!st.drone && st.smode) ? S_TOP_RD : S_FINISH;
				end else if (st.can_emit) begin
					cmd.rel_wr   = 1'b1;
					cmd.emit     = 1'b1;
					cmd.esel     = E_OFF_KEY;
					cmd.clr_mark = 1'b1;
					state_d      = S_FINISH;
				end
			end
			S_TOP_RD: begin
				cmd.st_top = 1'b1;
				state_d    = S_TOP_CHK;
			end
			S_TOP_CHK: begin
				cmd.st_top    = 1'b1;
				cmd.owner_set = 1'b1;
				cmd.idx_clr   = 1'b1;
				cmd.found_clr = 1'b1;
				state_d       = S_RM_RD;
			end
			S_RM_RD: begin
				state_d = st.rm_done ? S_RM_END : S_RM_CHK;
			end
			S_RM_CHK: begin
				if (!st.found && st.hit) cmd.found_set = 1'b1;
				else if (st.found) cmd.shift_wr = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d     = S_RM_RD;
			end
			S_RM_END: begin
				cmd.depth_dec = 1'b1;
				if (st.held_any) begin
					state_d = S_FINISH;
				end else if (st.owner) begin
					state_d = S_BACK_RD;
				end else begin
					cmd.clr_mark = 1'b1;
					state_d      = S_FINISH;
				end
			end
			S_BACK_RD: begin
				cmd.st_top = 1'b1;
				state_d    = S_BACK_CHK;
			end
			S_BACK_CHK: begin
				cmd.st_top = 1'b1;
				if (st.can_emit) begin
					cmd.emit     = 1'b1;
					cmd.esel     = st.depth_nz ? E_BACK_ON : E_OFF_KEY;
					cmd.clr_mark = 1'b1;
					state_d      = S_FINISH;
				end
			end
			S_FL_RD: begin
				cmd.scan_rd = 1'b1;
				state_d = st.fl_done ? S_FINISH : S_FL_CHK;
			end
			S_FL_CHK: begin
				cmd.scan_rd = 1'b1;
				if (!st.fl_hit) begin
					cmd.idx_inc = 1'b1;
					state_d     = S_FL_RD;
				end else if (st.can_emit) begin
					cmd.emit      = 1'b1;
					cmd.esel      = E_FLUSH;
					cmd.flush_clr = 1'b1;
					cmd.cnt_inc   = 1'b1;
					cmd.idx_inc   = 1'b1;
					state_d       = S_FL_RD;
				end
			end
			S_FINISH: begin
				if (!st.pend_v) begin
					state_d = S_IDLE;
				end else if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

### rtl/string_lane_note_priority_tracker.sv
// Channel  Direction  Payload
// s_*      in         requests: req_type, key_code, sustain_level
// m_*      out        note events, tlast on the final event of a request
// cfg_*    in         register writes: jam_rows, string_mode, drone_voicing
//
// One request is worked at a time; s_tready is high only while the block is idle.
// A release in string mode walks the lane's stack one entry at a time.
// A flush scans the note table key by key.
// The last event is held back in a pending register so that tlast can be set; m_tready stalls the scan.
// Reset clears the note table valid bits and lane depths at once; no clearing pass follows.
module string_lane_note_priority_tracker
	import slnpt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // req_type, key_code, sustain_level
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // event_kind, voice_id, lane, legato, drone_flag, interval
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_data
);

	cmd_t  cmd;
	stat_t st;
	res_t  out_res;

	slnpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	slnpt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.out_ready (m_tready),
		.cmd       (cmd),
		.st        (st),
		.out_valid (m_tvalid),
		.out_res   (out_res),
		.out_last  (m_tlast)
	);

	assign m_tdata = {6'd0, out_res};

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.can_emit) else $error("event issued with no room");

	a_finish_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> st.out_free) else $error("last event issued with no room");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !st.pend_v) else $error("idle with an event still held");

endmodule

### tb/tb_top.sv
module tb_top;
	import slnpt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [15:0] data;
	} request_t;

	typedef struct {
		res_t event_word;
		logic last;
	} note_event_t;

	typedef struct {
		bit       active;
		bit       physical;
		bit       sustained;
		bit       drone;
		bit [1:0] lane;
		bit [3:0] interval;
	} key_mark_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [2:0]  cfg_data;

	request_t    pending_requests[$];
	note_event_t expected_events[$];
	key_mark_t   key_marks[KEY_CODES];
	bit [5:0]    string_stack[LANES][STACK_DEPTH];
	int          string_depth[LANES];
	bit          pedal_down;
	bit          hold_on;
	bit [2:0]    jam_rows;
	bit          string_mode;
	bit [1:0]    drone_voicing;
	int          events_this_request;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          requests_queued;
	int          requests_taken;
	int          events_checked;
	int          errors;
	logic        holdoff_go;
	int          holdoff_left;
	bit [5:0]    held_keys[$];

	string_lane_note_priority_tracker u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic bit key_on_grid(bit [5:0] code, output bit [1:0] lane);
		int y;
		int x;
		int x0;
		lane = 0;
		if (code >= KEY_CODES) return 0;
		y = code / 14;
		x = code % 14;
		x0 = (y == 0) ? 1 : (y == 1) ? 1 : (y == 2) ? 2 : 3;
		lane = 2'(3 - y);
		return (x >= x0) && (x - x0 < GRID_COLS);
	endfunction

	function automatic void push_event(bit [1:0] kind, bit [6:0] voice, bit [2:0] lane,
			bit legato, bit drone, bit [3:0] interval);
		note_event_t e;
		if (events_this_request >= MAX_RESULTS) return;
		e.event_word = '{interval: interval, drone: drone, legato: legato, lane: lane,
			voice: voice, kind: kind};
		e.last = 0;
		expected_events.push_back(e);
		events_this_request++;
	endfunction

	function automatic int stack_top(int lane);
		return string_depth[lane] > 0 ? int'(string_stack[lane][string_depth[lane] - 1]) : -1;
	endfunction

	function automatic void stack_remove(int lane, bit [5:0] code);
		for (int i = 0; i < string_depth[lane]; i++) begin
			if (string_stack[lane][i] == code) begin
				for (int j = i; j + 1 < string_depth[lane]; j++)
					string_stack[lane][j] = string_stack[lane][j + 1];
				string_depth[lane]--;
				return;
			end
		end
	endfunction

	function automatic void flush_sustained_notes();
		for (int c = 0; c < KEY_CODES; c++) begin
			if (events_this_request >= MAX_RESULTS) return;
			if (key_marks[c].active && key_marks[c].sustained && !key_marks[c].physical) begin
				push_event(EV_OFF, 7'(c), key_marks[c].drone ? NO_LANE : {1'b0, key_marks[c].lane},
					0, 0, 0);
				key_marks[c] = '{default: 0};
			end
		end
	endfunction

	function automatic void predict_request(logic [15:0] word);
		bit [2:0] req;
		bit [5:0] code;
		bit       level;
		bit [1:0] lane;
		bit       legato;
		bit       owner;
		int       back;
		req = word[2:0];
		code = word[8:3];
		level = word[9];
		events_this_request = 0;
		case (req)
			REQ_PRESS: if (key_on_grid(code, lane)) begin
				if (lane < jam_rows) begin
					if (key_marks[code].active && key_marks[code].drone) begin
						if (key_marks[code].interval != 0) push_event(EV_OFF, code + 7'd64, NO_LANE, 0, 0, 0);
						push_event(EV_OFF, {1'b0, code}, NO_LANE, 0, 0, 0);
						key_marks[code] = '{default: 0};
					end else begin
						key_marks[code] = '{active: 1, physical: 1, sustained: 0, drone: 1, lane: lane,
							interval: drone_voicing == 2 ? 4'd7 : drone_voicing == 1 ? 4'd12 : 4'd0};
						push_event(EV_ON, {1'b0, code}, NO_LANE, 0, 1, 0);
						if (key_marks[code].interval != 0)
							push_event(EV_ON, code + 7'd64, NO_LANE, 0, 1, key_marks[code].interval);
					end
				end else begin
					key_marks[code] = '{active: 1, physical: 1, sustained: 0, drone: 0, lane: lane,
						interval: 0};
					legato = 0;
					if (string_mode) begin
						legato = string_depth[lane] > 0;
						if (string_depth[lane] < STACK_DEPTH) begin
							string_stack[lane][string_depth[lane]] = code;
							string_depth[lane]++;
						end
					end
					push_event(EV_ON, {1'b0, code}, {1'b0, lane}, legato, 0, 0);
				end
			end
			REQ_RELEASE: if (key_on_grid(code, lane) && key_marks[code].active) begin
				key_marks[code].physical = 0;
				if (!key_marks[code].drone) begin
					lane = key_marks[code].lane;
					if (pedal_down || hold_on) begin
						key_marks[code].sustained = 1;
						if (string_mode) stack_remove(lane, code);
					end else if (string_mode) begin
						owner = stack_top(lane) == int'(code);
						stack_remove(lane, code);
						if (owner) begin
							back = stack_top(lane);
							if (back >= 0) push_event(EV_ON, 7'(back), {1'b0, lane}, 1, 0, 0);
							else push_event(EV_OFF, {1'b0, code}, {1'b0, lane}, 0, 0, 0);
						end
						key_marks[code] = '{default: 0};
					end else begin
						push_event(EV_OFF, {1'b0, code}, {1'b0, lane}, 0, 0, 0);
						key_marks[code] = '{default: 0};
					end
				end
			end
			REQ_SUSTAIN: begin
				if (pedal_down && !level && !hold_on) flush_sustained_notes();
				pedal_down = level;
			end
			REQ_HOLD: begin
				hold_on = !hold_on;
				if (!hold_on) flush_sustained_notes();
			end
			REQ_ALL_OFF: begin
				push_event(EV_ALL, 0, NO_LANE, 0, 0, 0);
				foreach (key_marks[c]) key_marks[c] = '{default: 0};
				foreach (string_depth[l]) string_depth[l] = 0;
			end
			REQ_LEADS_OFF: begin
				push_event(EV_LEADS, 0, NO_LANE, 0, 0, 0);
				foreach (key_marks[c])
					if (!(key_marks[c].drone && key_marks[c].active)) key_marks[c] = '{default: 0};
				foreach (string_depth[l]) string_depth[l] = 0;
			end
			default: ;
		endcase
		if (events_this_request > 0) expected_events[$].last = 1;
	endfunction

	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			predict_request(s_tdata);
			requests_taken++;
		end
		if (!s_tvalid || s_tready) begin
			if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1;
				s_tdata <= pending_requests.pop_front().data;
			end else begin
				s_tvalid <= 0;
			end
		end
	end

	always @(posedge clk) begin
		if (holdoff_go) begin
			holdoff_left <= 400;
			m_tready <= 0;
		end else if (holdoff_left > 0) begin
			holdoff_left <= holdoff_left - 1;
			m_tready <= 0;
		end else begin
			m_tready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		note_event_t e;
		res_t got;
		if (m_tvalid && m_tready) begin
			got = res_t'(m_tdata[17:0]);
			events_checked++;
			if (expected_events.size() == 0) begin
				$display("%0t: unexpected event, expected none, actual %h last %b",
					$time, m_tdata, m_tlast);
				errors++;
			end else begin
				e = expected_events.pop_front();
				if (got.kind != e.event_word.kind || got.voice != e.event_word.voice ||
						got.lane != e.event_word.lane || got.legato != e.event_word.legato ||
						got.drone != e.event_word.drone || got.interval != e.event_word.interval ||
						m_tlast != e.last || m_tdata[23:18] != 0) begin
					$display("%0t: event mismatch, expected kind %0d voice %0d lane %0d leg %0d drone %0d ivl %0d last %0d, actual kind %0d voice %0d lane %0d leg %0d drone %0d ivl %0d last %0d",
						$time, e.event_word.kind, e.event_word.voice, e.event_word.lane,
						e.event_word.legato, e.event_word.drone, e.event_word.interval, e.last,
						got.kind, got.voice, got.lane, got.legato, got.drone, got.interval, m_tlast);
					errors++;
				end
			end
		end
	end

	task automatic queue_request(req_t req, bit [5:0] code, bit level);
		request_t r;
		r.data = {6'd0, level, code, req};
		pending_requests.push_back(r);
		requests_queued++;
	endtask

	task automatic queue_raw(bit [2:0] req, bit [5:0] code, bit level);
		request_t r;
		r.data = {6'd0, level, code, req};
		pending_requests.push_back(r);
		requests_queued++;
	endtask

	function automatic bit [5:0] random_grid_key();
		int y;
		y = $urandom_range(3);
		return 6'(y * 14 + ((y < 2) ? 1 : y == 2 ? 2 : 3) + $urandom_range(GRID_COLS - 1));
	endfunction

	task automatic queue_random(int count);
		int pick;
		bit [5:0] code;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				code = random_grid_key();
				held_keys.push_back(code);
				queue_request(REQ_PRESS, code, 1'($urandom_range(1)));
			end else if (pick < 72 && held_keys.size() > 0) begin
				code = held_keys[$urandom_range(held_keys.size() - 1)];
				queue_request(REQ_RELEASE, code, 1'($urandom_range(1)));
			end else if (pick < 82) begin
				queue_request(REQ_SUSTAIN, 6'($urandom_range(63)), 1'($urandom_range(1)));
			end else if (pick < 88) begin
				queue_request(REQ_HOLD, 6'($urandom_range(63)), 1'($urandom_range(1)));
			end else if (pick < 91) begin
				queue_request(REQ_ALL_OFF, 6'($urandom_range(63)), 1'($urandom_range(1)));
				held_keys.delete();
			end else if (pick < 94) begin
				queue_request(REQ_LEADS_OFF, 6'($urandom_range(63)), 1'($urandom_range(1)));
			end else begin
				queue_raw(3'($urandom_range(7)), 6'($urandom_range(63)), 1'($urandom_range(1)));
			end
			if (held_keys.size() > 12) void'(held_keys.pop_front());
		end
	endtask

	task automatic write_register(logic [1:0] index, logic [2:0] value);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 0;
		case (index)
			CFG_JAM:     jam_rows = value;
			CFG_SMODE:   string_mode = value[0];
			CFG_VOICING: drone_voicing = value[1:0];
			default: ;
		endcase
	endtask

	task automatic wait_until_drained();
		while (requests_taken != requests_queued || expected_events.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic set_phase(logic [2:0] jam, logic smode, logic [1:0] voicing,
			int idle_pct, int stall_pct);
		wait_until_drained();
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		write_register(CFG_JAM, jam);
		write_register(CFG_SMODE, {2'd0, smode});
		write_register(CFG_VOICING, {1'b0, voicing});
	endtask

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		clk = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		m_tready = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		holdoff_go = 0;
		holdoff_left = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		errors = 0;
		foreach (key_marks[c]) key_marks[c] = '{default: 0};
		foreach (string_depth[l]) string_depth[l] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		set_phase(3'd0, 1'b1, 2'd0, 0, 0);
		queue_request(REQ_PRESS, 6'd1, 0);
		queue_request(REQ_PRESS, 6'd2, 0);
		queue_request(REQ_PRESS, 6'd10, 0);
		queue_request(REQ_RELEASE, 6'd2, 0);
		queue_request(REQ_RELEASE, 6'd10, 0);
		queue_request(REQ_RELEASE, 6'd1, 0);
		queue_request(REQ_PRESS, 6'd0, 1);
		queue_request(REQ_RELEASE, 6'd55, 1);
		queue_request(REQ_PRESS, 6'd63, 0);
		queue_request(REQ_RELEASE, 6'd5, 0);
		queue_request(REQ_PRESS, 6'd15, 0);
		queue_request(REQ_PRESS, 6'd15, 0);
		queue_request(REQ_RELEASE, 6'd15, 0);
		queue_request(REQ_SUSTAIN, 6'd0, 1);
		queue_request(REQ_PRESS, 6'd45, 0);
		queue_request(REQ_RELEASE, 6'd45, 0);
		queue_request(REQ_HOLD, 6'd0, 0);
		queue_request(REQ_SUSTAIN, 6'd0, 0);
		queue_request(REQ_HOLD, 6'd0, 0);
		queue_raw(3'd6, 6'd42, 1);
		queue_raw(3'd7, 6'd63, 1);
		for (int i = 0; i < 17; i++) queue_request(REQ_PRESS, 6'(30 + i % 10), 0);
		queue_request(REQ_RELEASE, 6'd36, 0);
		queue_request(REQ_ALL_OFF, 6'd0, 0);

		set_phase(3'd2, 1'b1, 2'd1, 84, 0);
		queue_request(REQ_PRESS, 6'd40, 0);
		queue_request(REQ_PRESS, 6'd40, 0);
		queue_request(REQ_PRESS, 6'd45, 0);
		queue_request(REQ_SUSTAIN, 6'd0, 1);
		queue_request(REQ_RELEASE, 6'd45, 0);
		queue_request(REQ_PRESS, 6'd16, 0);
		queue_request(REQ_RELEASE, 6'd16, 0);
		queue_request(REQ_LEADS_OFF, 6'd0, 0);
		queue_request(REQ_SUSTAIN, 6'd0, 0);
		queue_random(20);

		set_phase(3'd4, 1'b0, 2'd2, 0, 84);
		queue_random(20);

		set_phase(3'd7, 1'b1, 2'd3, 20, 20);
		queue_random(15);

		set_phase(3'd1, 1'b1, 2'd2, 0, 0);
		@(posedge clk);
		holdoff_go <= 1;
		@(posedge clk);
		holdoff_go <= 0;
		queue_random(25);

		wait_until_drained();
		$display("Ran %0d requests over five register settings and checked %0d note events.",
			requests_taken, events_checked);
		$display("Directed pedal, hold, drone and stack cases preceded the random traffic.");
		if (errors == 0 && expected_events.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
